// ===== design/sra_pkg.sv =====
// Package for the stack region allocator: sizes, operation codes and state type.
`timescale 1ns / 1ps

package sra_pkg;

  // Region and block limits
  localparam int REGION_MAX_BYTES = 65536;
  localparam int HEADER_BYTES     = 16;   // power of two, rounding is a mask
  localparam int MAX_BLOCKS       = 4096;

  // Field and counter widths
  localparam int FIELD_W = 17;
  localparam int WIDE_W  = FIELD_W + 2;
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int OP_W    = 2;

  // Operation codes carried on the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_PEEK = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_t;

  // Round up to a multiple of the header size
  function automatic logic [WIDE_W-1:0] round_hdr(input logic [WIDE_W-1:0] n);
    logic [WIDE_W-1:0] s;
    s = n + WIDE_W'(HEADER_BYTES - 1);
    return s & ~WIDE_W'(HEADER_BYTES - 1);
  endfunction

endpackage

// ===== design/stack_region_allocator_core.sv =====
// Stack region allocator: top level with offset memory, top-of-stack registers and output stage.
`timescale 1ns / 1ps

// Keeps one byte region as a stack of blocks, each a 16-byte header plus data
// rounded up to 16 bytes. Input beats carry the operation in s_tuser (push,
// peek, pop) and the push size in s_tdata; every beat gives one result beat
// with ok in m_tuser and the data offset and free bytes in m_tdata. Push and
// peek are answered in the idle state; a pop also goes through the fill state,
// where the new top-of-stack offset is read back from the block offset memory
// before the next beat is taken. The top offset, next free offset and free byte
// count live in registers. A result beat waiting in the output register does
// not block the next input beat while the output side takes it. Writing the
// region size empties the stack; there is no clearing pass after reset.
module stack_region_allocator_core (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: region size in bytes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sra_pkg::FIELD_W-1:0] cfg_data,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // [16:0] request_size, rest zero
  input  logic [sra_pkg::OP_W-1:0]    s_tuser,   // [1:0] operation
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,   // [16:0] data_offset, [33:17] space_left
  output logic                        m_tuser    // [0] ok
);
  import sra_pkg::*;

  // Block data offsets, indexed by stack position
  logic [FIELD_W-1:0] offset_mem [MAX_BLOCKS];
  logic [FIELD_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;

  // Control and top-of-stack registers
  state_t             state, state_next;
  logic [CNT_W-1:0]   block_count, block_count_next;
  logic [FIELD_W-1:0] next_free, next_free_next;
  logic [FIELD_W-1:0] free_bytes, free_bytes_next;
  logic [FIELD_W-1:0] region_size, region_size_next;
  logic [FIELD_W-1:0] top_off, top_off_next;

  // Output register
  logic               out_ok, out_ok_next;
  logic [FIELD_W-1:0] out_offset, out_offset_next;
  logic [FIELD_W-1:0] out_space, out_space_next;
  logic               m_tvalid_next;

  // Datapath terms
  logic [FIELD_W-1:0] req;
  logic [WIDE_W-1:0]  need, need_hdr, data_wide, cfg_sat, cfg_round;
  logic               fits, in_beat, cfg_beat, not_empty;
  op_t                op;

  assign req       = s_tdata[FIELD_W-1:0];
  assign op        = op_t'(s_tuser);
  assign cfg_ready = (state == ST_IDLE);
  assign s_tready  = (state == ST_IDLE) && !cfg_valid && (!m_tvalid || m_tready);
  assign in_beat   = s_tvalid && s_tready;
  assign cfg_beat  = cfg_valid && cfg_ready;
  assign not_empty = (block_count != '0);

  // Push fit check
  assign need      = round_hdr({2'b00, req});
  assign need_hdr  = need + WIDE_W'(HEADER_BYTES);
  assign fits      = (block_count < CNT_W'(MAX_BLOCKS)) && (need_hdr <= {2'b00, free_bytes});
  assign data_wide = {2'b00, next_free} + WIDE_W'(HEADER_BYTES);

  // Region size: saturate, then round
  assign cfg_sat   = ({2'b00, cfg_data} > WIDE_W'(REGION_MAX_BYTES)) ?
                     WIDE_W'(REGION_MAX_BYTES) : {2'b00, cfg_data};
  assign cfg_round = round_hdr(cfg_sat);

  // Memory ports: push writes at the count, reads follow the entry below top
  assign wr_en   = in_beat && (op == OP_PUSH) && fits;
  assign rd_addr = block_count[IDX_W-1:0] - IDX_W'(2);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      offset_mem[block_count[IDX_W-1:0]] <= data_wide[FIELD_W-1:0];
    end
    rd_data <= offset_mem[rd_addr];
  end

  // Next state and register updates
  always_comb begin
    state_next        = state;
    block_count_next  = block_count;
    next_free_next    = next_free;
    free_bytes_next   = free_bytes;
    region_size_next  = region_size;
    top_off_next      = top_off;
    out_ok_next       = out_ok;
    out_offset_next   = out_offset;
    out_space_next    = out_space;
    m_tvalid_next     = m_tvalid && !m_tready;

    case (state)
      ST_IDLE: begin
        if (cfg_beat) begin
          region_size_next = cfg_round[FIELD_W-1:0];
          free_bytes_next  = cfg_round[FIELD_W-1:0];
          next_free_next   = '0;
          block_count_next = '0;
        end else if (in_beat) begin
          m_tvalid_next   = 1'b1;
          out_ok_next     = 1'b0;
          out_offset_next = '0;
          out_space_next  = free_bytes;
          case (op)
            OP_PUSH: begin
              if (fits) begin
                out_ok_next      = 1'b1;
                out_offset_next  = data_wide[FIELD_W-1:0];
                top_off_next     = data_wide[FIELD_W-1:0];
                next_free_next   = data_wide[FIELD_W-1:0] + need[FIELD_W-1:0];
                free_bytes_next  = free_bytes - need_hdr[FIELD_W-1:0];
                out_space_next   = free_bytes - need_hdr[FIELD_W-1:0];
                block_count_next = block_count + CNT_W'(1);
              end
            end
            OP_PEEK: begin
              if (not_empty) begin
                out_ok_next     = 1'b1;
                out_offset_next = top_off;
              end
            end
            OP_POP: begin
              if (not_empty) begin
                out_ok_next      = 1'b1;
                out_offset_next  = top_off;
                next_free_next   = top_off - FIELD_W'(HEADER_BYTES);
                free_bytes_next  = region_size - (top_off - FIELD_W'(HEADER_BYTES));
                out_space_next   = region_size - (top_off - FIELD_W'(HEADER_BYTES));
                block_count_next = block_count - CNT_W'(1);
                state_next       = ST_FILL;
              end
            end
            default: begin
              out_ok_next = 1'b0;
            end
          endcase
        end
      end
      ST_FILL: begin
        // new top offset arrives from the memory
        top_off_next = rd_data;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      block_count <= '0;
      next_free   <= '0;
      free_bytes  <= FIELD_W'(REGION_MAX_BYTES);
      region_size <= FIELD_W'(REGION_MAX_BYTES);
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      block_count <= block_count_next;
      next_free   <= next_free_next;
      free_bytes  <= free_bytes_next;
      region_size <= region_size_next;
      m_tvalid    <= m_tvalid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_off    <= top_off_next;
    out_ok     <= out_ok_next;
    out_offset <= out_offset_next;
    out_space  <= out_space_next;
  end

  assign m_tuser = out_ok;
  assign m_tdata = {6'd0, out_space, out_offset};

`ifndef SYNTHESIS
  // stack depth never passes the table size
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    block_count <= CNT_W'(MAX_BLOCKS))
    else $error("block count above table size");

  // a successful pop always fetches the new top
  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    in_beat && (op == OP_POP) && not_empty |=> state == ST_FILL)
    else $error("pop did not refill top offset");

  // used plus free bytes add up to the region
  a_space_sum: assert property (@(posedge clk) disable iff (rst)
    ({2'b00, next_free} + {2'b00, free_bytes}) == {2'b00, region_size})
    else $error("free space bookkeeping broken");

  // no beat taken while the top offset is being refilled
  a_fill_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> !s_tready)
    else $error("input taken during refill");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the stack region allocator: stimulus, allocation predictor and result checker.
`timescale 1ns / 1ps

module tb_top;
  import sra_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 6;     // pop needs a memory read-back before idle
  localparam int DRAIN_CYCLES  = 12;
  localparam int PHASE_ITEMS   = 190;
  localparam int DIR_ROWS      = 29;

  // Operation code the block ignores
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  // Directed row kinds
  localparam logic ROW_ITEM = 1'b0;
  localparam logic ROW_CFG  = 1'b1;

  typedef struct packed {
    logic              ok;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] space;
  } alloc_result_t;

  typedef struct packed {
    logic               kind;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] arg;     // push size, or region size on a config row
    logic               typed;   // expected result given in the row
    alloc_result_t      want;
  } dir_row_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FIELD_W-1:0] cfg_data  = '0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [23:0]        s_tdata   = '0;
  logic [OP_W-1:0]    s_tuser   = OP_PUSH;
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [39:0]        m_tdata;
  logic               m_tuser;

  stack_region_allocator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // Allocator state as predicted
  int unsigned blk_data_off [MAX_BLOCKS];
  int unsigned blk_data_len [MAX_BLOCKS];
  int unsigned stack_depth = 0;
  int unsigned next_hdr    = 0;
  int unsigned free_left   = REGION_MAX_BYTES;

  alloc_result_t expected_q [$];

  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned ready_hold  = 0;
  bit          steady      = 1'b0;   // no gaps on either side while set
  int unsigned n_beats     = 0;
  int unsigned n_push_ok   = 0;
  int unsigned n_push_fail = 0;
  int unsigned n_pops      = 0;
  int unsigned n_peeks     = 0;
  int unsigned n_cfg       = 0;
  int unsigned max_depth   = 0;

  // Directed table: ops after reset, edge sizes, region extremes
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, OP_PEEK, 17'd0,      1'b1, '{1'b0, 17'd0,  17'd65536}},
    '{ROW_ITEM, OP_POP,  17'd0,      1'b1, '{1'b0, 17'd0,  17'd65536}},
    '{ROW_ITEM, OP_NONE, 17'd0,      1'b1, '{1'b0, 17'd0,  17'd65536}},
    '{ROW_ITEM, OP_PUSH, 17'd0,      1'b1, '{1'b1, 17'd16, 17'd65520}},
    '{ROW_ITEM, OP_PEEK, 17'd0,      1'b1, '{1'b1, 17'd16, 17'd65520}},
    '{ROW_ITEM, OP_PUSH, 17'd1,      1'b1, '{1'b1, 17'd32, 17'd65488}},
    '{ROW_ITEM, OP_PUSH, 17'd17,     1'b0, '0},
    '{ROW_ITEM, OP_PUSH, 17'd65536,  1'b1, '{1'b0, 17'd0,  17'd65440}},
    '{ROW_ITEM, OP_PUSH, 17'd65535,  1'b0, '0},
    '{ROW_ITEM, OP_POP,  17'd0,      1'b0, '0},
    '{ROW_ITEM, OP_POP,  17'd0,      1'b0, '0},
    '{ROW_ITEM, OP_POP,  17'd0,      1'b1, '{1'b1, 17'd16, 17'd65536}},
    '{ROW_ITEM, OP_POP,  17'd0,      1'b1, '{1'b0, 17'd0,  17'd65536}},
    '{ROW_ITEM, OP_PUSH, 17'd65520,  1'b1, '{1'b1, 17'd16, 17'd0}},
    '{ROW_ITEM, OP_PUSH, 17'd0,      1'b1, '{1'b0, 17'd0,  17'd0}},
    '{ROW_ITEM, OP_PEEK, 17'd0,      1'b1, '{1'b1, 17'd16, 17'd0}},
    '{ROW_ITEM, OP_POP,  17'd0,      1'b1, '{1'b1, 17'd16, 17'd65536}},
    '{ROW_ITEM, OP_PUSH, 17'd65521,  1'b1, '{1'b0, 17'd0,  17'd65536}},
    '{ROW_CFG,  OP_PUSH, 17'd0,      1'b0, '0},
    '{ROW_ITEM, OP_PUSH, 17'd0,      1'b1, '{1'b0, 17'd0,  17'd0}},
    '{ROW_CFG,  OP_PUSH, 17'd131071, 1'b0, '0},
    '{ROW_ITEM, OP_PEEK, 17'd0,      1'b1, '{1'b0, 17'd0,  17'd65536}},
    '{ROW_CFG,  OP_PUSH, 17'd17,     1'b0, '0},
    '{ROW_ITEM, OP_PUSH, 17'd0,      1'b1, '{1'b1, 17'd16, 17'd16}},
    '{ROW_ITEM, OP_PUSH, 17'd0,      1'b1, '{1'b1, 17'd32, 17'd0}},
    '{ROW_CFG,  OP_PUSH, 17'd16,     1'b0, '0},
    '{ROW_ITEM, OP_PUSH, 17'd0,      1'b1, '{1'b1, 17'd16, 17'd0}},
    '{ROW_ITEM, OP_POP,  17'd0,      1'b1, '{1'b1, 17'd16, 17'd16}},
    '{ROW_CFG,  OP_PUSH, 17'd65536,  1'b0, '0}
  };

  // Region write: saturate, round up to the header size, empty the stack
  function automatic void load_region(input logic [FIELD_W-1:0] value);
    int unsigned r;
    r = 32'(value);
    if (r > REGION_MAX_BYTES) r = REGION_MAX_BYTES;
    free_left   = ((r + HEADER_BYTES - 1) / HEADER_BYTES) * HEADER_BYTES;
    stack_depth = 0;
    next_hdr    = 0;
  endfunction

  // Predict one operation and advance the stack
  function automatic alloc_result_t apply_op(input logic [OP_W-1:0] op,
                                             input logic [FIELD_W-1:0] size);
    alloc_result_t r;
    int unsigned   need;
    r = '0;
    case (op)
      OP_PUSH: begin
        need = ((int'(size) + HEADER_BYTES - 1) / HEADER_BYTES) * HEADER_BYTES;
        if (stack_depth < MAX_BLOCKS && need + HEADER_BYTES <= free_left) begin
          r.ok     = 1'b1;
          r.offset = FIELD_W'(next_hdr + HEADER_BYTES);
          blk_data_off[stack_depth] = next_hdr + HEADER_BYTES;
          blk_data_len[stack_depth] = need;
          free_left   -= need + HEADER_BYTES;
          next_hdr    += need + HEADER_BYTES;
          stack_depth += 1;
          n_push_ok++;
          if (stack_depth > max_depth) max_depth = stack_depth;
        end else begin
          n_push_fail++;
        end
      end
      OP_PEEK, OP_POP: begin
        if (stack_depth != 0) begin
          r.ok     = 1'b1;
          r.offset = FIELD_W'(blk_data_off[stack_depth-1]);
          if (op == OP_POP) begin
            free_left  += blk_data_len[stack_depth-1] + HEADER_BYTES;
            next_hdr    = blk_data_off[stack_depth-1] - HEADER_BYTES;
            stack_depth -= 1;
          end
        end
        if (op == OP_POP) n_pops++;
        else n_peeks++;
      end
      default: ;
    endcase
    r.space = FIELD_W'(free_left);
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Drive one input beat; valid stays high when the next beat follows at once
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] size,
                           input bit typed, input alloc_result_t want);
    int unsigned   gap;
    alloc_result_t res;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, size};
    do @(posedge clk); while (!s_tready);
    res = apply_op(op, size);
    expected_q.push_back(typed ? want : res);
    n_beats++;
  endtask

  // Region write once the block has gone idle
  task automatic write_region(input logic [FIELD_W-1:0] value);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    load_region(value);
    n_cfg++;
  endtask

  // Random traffic: pushes of mixed sizes, pops, peeks, some ignored codes
  task automatic random_phase(input int unsigned n_items);
    int unsigned    done;
    int unsigned    r;
    logic [OP_W-1:0] op;
    logic [FIELD_W-1:0] size;
    done = 0;
    while (done < n_items) begin
      r    = $urandom_range(0, 99);
      op   = (r < 50) ? OP_PUSH : (r < 75) ? OP_POP : (r < 92) ? OP_PEEK : OP_NONE;
      r    = $urandom_range(0, 99);
      if (r < 60) size = FIELD_W'($urandom_range(0, 64));
      else if (r < 85) size = FIELD_W'($urandom_range(0, 1024));
      else if (r < 93) size = FIELD_W'($urandom_range(0, REGION_MAX_BYTES));
      else if (free_left >= HEADER_BYTES)
        // exact fit, or one byte past it
        size = FIELD_W'(free_left - HEADER_BYTES + $urandom_range(0, 1));
      else size = $urandom_range(0, 1) ? FIELD_W'(REGION_MAX_BYTES) : '0;
      send_beat(op, size, 1'b0, '0);
      if (op != OP_NONE) done++;
    end
  endtask

  // Result side: random back-pressure and the check of each beat
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no request pending: ok=%0b offset=%0d space=%0d",
               m_tuser, m_tdata[16:0], m_tdata[33:17]);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_tuser !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, m_tuser);
          errors++;
        end
        if (m_tdata[16:0] !== want.offset) begin
          $error("data_offset: expected %0d, got %0d", want.offset, m_tdata[16:0]);
          errors++;
        end
        if (m_tdata[33:17] !== want.space) begin
          $error("space_left: expected %0d, got %0d", want.space, m_tdata[33:17]);
          errors++;
        end
      end
    end
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 30) ready_hold <= pick_gap();
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("timeout with %0d results outstanding", expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [FIELD_W-1:0] region_plan [8];
    region_plan = '{17'd65536, 17'd16, 17'd0, 17'd131071, 17'd17,
                    FIELD_W'($urandom_range(32, 2048)),
                    FIELD_W'($urandom_range(2048, 65535)), 17'd65535};
    load_region(FIELD_W'(REGION_MAX_BYTES));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) write_region(dir_rows[i].arg);
      else send_beat(dir_rows[i].op, dir_rows[i].arg, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases over a spread of region sizes
    for (int p = 0; p < 8; p++) begin
      write_region(region_plan[p]);
      steady = ($urandom_range(0, 3) == 0);
      random_phase(PHASE_ITEMS);
    end

    // Full region again: extreme pushes and a peek, then a short random tail
    write_region(FIELD_W'(REGION_MAX_BYTES));
    steady = 1'b0;
    send_beat(OP_PUSH, '0, 1'b0, '0);
    send_beat(OP_PUSH, FIELD_W'(REGION_MAX_BYTES), 1'b0, '0);
    send_beat(OP_PEEK, '0, 1'b0, '0);
    random_phase(40);

    // Drain
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d beats over %0d region writes: %0d pushes granted, %0d refused,",
             n_beats, n_cfg, n_push_ok, n_push_fail);
    $display("%0d pops, %0d peeks, deepest stack %0d blocks", n_pops, n_peeks, max_depth);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
